[rtl/core/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared codes and default sizes for the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int DEF_BUCKET_COUNT = 64;
	localparam int DEF_NODE_COUNT   = 128;
	localparam int DEF_KEY_BITS     = 32;
	localparam int DEF_VALUE_BITS   = 32;

	localparam int FIELD_BITS = 32;

	typedef enum logic [1:0] {
		CMD_GET      = 2'd0,
		CMD_PUT      = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_CONTAINS = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_e_t;

endpackage

[rtl/core/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Takes items, masks the key, computes the bucket and queues them for the back.
// ----------------------------------------------------------------------------
module chm_front #(
	parameter int BUCKET_COUNT = chm_pkg::DEF_BUCKET_COUNT,
	parameter int KEY_BITS     = chm_pkg::DEF_KEY_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      clearing,
	input  logic                                      push,
	output logic                                      full,
	input  logic [1:0]                                command,
	input  logic [chm_pkg::FIELD_BITS-1:0]            key,
	input  logic [chm_pkg::FIELD_BITS-1:0]            value,
	output logic                                      q_empty,
	input  logic                                      q_pop,
	output logic [1:0]                                q_command,
	output logic [chm_pkg::FIELD_BITS-1:0]            q_key,
	output logic [chm_pkg::FIELD_BITS-1:0]            q_value,
	output logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] q_bucket
);
	import chm_pkg::*;

	localparam int BW      = BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1;
	localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
	localparam int DIGITS  = FIELD_BITS / 4;
	localparam int CW      = $clog2(DIGITS + 1);
	localparam logic [FIELD_BITS-1:0] KMASK = KEY_BITS >= FIELD_BITS ? '1 :
		FIELD_BITS'((64'd1 << KEY_BITS) - 64'd1);

	// staging register: bucket is worked out here, 4 key bits per cycle unless BUCKET_COUNT is a power of two
	logic                  stg_valid_q;
	logic [1:0]            stg_cmd_q;
	logic [FIELD_BITS-1:0] stg_key_q;
	logic [FIELD_BITS-1:0] stg_val_q;
	logic [FIELD_BITS-1:0] sh_q;
	logic [BW-1:0]         rem_q;
	logic [BW-1:0]         rem_next;
	logic [CW-1:0]         cnt_q;
	logic                  done;
	logic                  stg_move;
	logic                  accept;
	logic [BW-1:0]         stg_bucket;

	// two-entry queue toward the back
	logic [1:0]            fq_cmd_q    [2];
	logic [FIELD_BITS-1:0] fq_key_q    [2];
	logic [FIELD_BITS-1:0] fq_val_q    [2];
	logic [BW-1:0]         fq_bkt_q    [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fq_cnt_q;

	assign done       = IS_POW2 ? 1'b1 : (cnt_q == CW'(DIGITS));
	assign stg_move   = stg_valid_q && done && (fq_cnt_q != 2'd2);
	assign full       = clearing || (stg_valid_q && !stg_move);
	assign accept     = push && !full;
	assign stg_bucket = IS_POW2 ? BW'(stg_key_q & FIELD_BITS'(BUCKET_COUNT - 1)) : rem_q;

	always_comb begin
		logic [BW:0] t;
		logic [BW-1:0] r;
		r = rem_q;
		for (int j = 0; j < 4; j++) begin
			t = {r, sh_q[FIELD_BITS-1-j]};
			if (t >= (BW+1)'(BUCKET_COUNT))
				t = t - (BW+1)'(BUCKET_COUNT);
			r = t[BW-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (accept) begin
				stg_valid_q <= 1'b1;
				cnt_q       <= '0;
			end else if (stg_move) begin
				stg_valid_q <= 1'b0;
			end else if (stg_valid_q && !done) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stg_cmd_q <= command;
			stg_key_q <= key & KMASK;
			stg_val_q <= value;
			sh_q      <= key & KMASK;
			rem_q     <= '0;
		end else if (stg_valid_q && !done) begin
			sh_q  <= sh_q << 4;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fq_cnt_q <= '0;
		end else begin
			if (stg_move)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop && !q_empty)
				rd_ptr_q <= !rd_ptr_q;
			fq_cnt_q <= fq_cnt_q + 2'(stg_move) - 2'(q_pop && !q_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (stg_move) begin
			fq_cmd_q[wr_ptr_q] <= stg_cmd_q;
			fq_key_q[wr_ptr_q] <= stg_key_q;
			fq_val_q[wr_ptr_q] <= stg_val_q;
			fq_bkt_q[wr_ptr_q] <= stg_bucket;
		end
	end

	assign q_empty   = fq_cnt_q == 2'd0;
	assign q_command = fq_cmd_q[rd_ptr_q];
	assign q_key     = fq_key_q[rd_ptr_q];
	assign q_value   = fq_val_q[rd_ptr_q];
	assign q_bucket  = fq_bkt_q[rd_ptr_q];

endmodule

[rtl/core/chm_back.sv]
// ----------------------------------------------------------------------------
// chm_back
// Walks the bucket chain, applies the command and holds the result register.
// ----------------------------------------------------------------------------
module chm_back #(
	parameter int BUCKET_COUNT = chm_pkg::DEF_BUCKET_COUNT,
	parameter int NODE_COUNT   = chm_pkg::DEF_NODE_COUNT,
	parameter int KEY_BITS     = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS   = chm_pkg::DEF_VALUE_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	output logic                                      clearing,
	input  logic                                      q_empty,
	output logic                                      q_pop,
	input  logic [1:0]                                q_command,
	input  logic [chm_pkg::FIELD_BITS-1:0]            q_key,
	input  logic [chm_pkg::FIELD_BITS-1:0]            q_value,
	input  logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] q_bucket,
	output logic                                      empty,
	input  logic                                      pop,
	output logic                                      found,
	output logic [chm_pkg::FIELD_BITS-1:0]            read_value,
	output logic [1:0]                                status
);
	import chm_pkg::*;

	localparam int BW = BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1;
	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int AW = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;
	localparam int KW = KEY_BITS < FIELD_BITS ? KEY_BITS : FIELD_BITS;
	localparam int VW = VALUE_BITS < FIELD_BITS ? VALUE_BITS : FIELD_BITS;
	localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_HEAD, S_NODE, S_EXEC, S_LINK, S_REPLY
	} state_t;

	logic [NW-1:0] bucket_mem [BUCKET_COUNT];
	logic [KW-1:0] key_mem    [NODE_COUNT];
	logic [VW-1:0] val_mem    [NODE_COUNT];
	logic [NW-1:0] next_mem   [NODE_COUNT];

	state_t        state_q;
	cmd_e_t        cmd_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] clr_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] prev_q;
	logic [NW-1:0] fresh_q;
	logic [NW-1:0] free_head_q;
	logic [NW-1:0] fill_q;
	logic          hit_q;
	logic          nofree_q;
	logic [VW-1:0] hitval_q;
	logic [NW-1:0] hitnext_q;
	logic          out_valid_q;
	logic          out_found_q;
	logic [VW-1:0] out_val_q;
	status_e_t     out_status_q;

	logic [NW-1:0] bh_rd_q;
	logic [KW-1:0] key_rd_q;
	logic [VW-1:0] val_rd_q;
	logic [NW-1:0] nxt_rd_q;

	logic          bh_we;
	logic [BW-1:0] bh_waddr;
	logic [NW-1:0] bh_wdata;
	logic          nd_we;
	logic [NW-1:0] nv_waddr;
	logic          nv_we;
	logic          nn_we;
	logic [NW-1:0] nn_waddr;
	logic [NW-1:0] nn_wdata;
	logic [NW-1:0] nd_raddr;
	logic [NW-1:0] link;
	status_e_t     res_status;

	assign link = (cmd_q == CMD_PUT) ? fresh_q : hitnext_q;

	always_comb begin
		bh_we    = 1'b0;
		bh_waddr = bkt_q;
		bh_wdata = link;
		nd_we    = 1'b0;
		nv_we    = 1'b0;
		nv_waddr = cur_q;
		nn_we    = 1'b0;
		nn_waddr = prev_q;
		nn_wdata = link;
		nd_raddr = cur_q;
		case (state_q)
			S_CLR: begin
				bh_we    = 1'b1;
				bh_waddr = clr_q;
				bh_wdata = NIL;
			end
			S_HEAD: nd_raddr = bh_rd_q;
			S_NODE: nd_raddr = nxt_rd_q;
			S_EXEC: begin
				nd_raddr = free_head_q;
				if (cmd_q == CMD_PUT && hit_q) begin
					nv_we = 1'b1;
				end else if (cmd_q == CMD_PUT && free_head_q != NIL) begin
					nd_we    = 1'b1;
					nv_we    = 1'b1;
					nv_waddr = free_head_q;
					nn_we    = 1'b1;
					nn_waddr = free_head_q;
					nn_wdata = NIL;
				end else if (cmd_q == CMD_REMOVE && hit_q) begin
					nn_we    = 1'b1;
					nn_waddr = cur_q;
					nn_wdata = free_head_q;
				end
			end
			S_LINK: begin
				if (prev_q == NIL)
					bh_we = 1'b1;
				else
					nn_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bh_we)
			bucket_mem[bh_waddr] <= bh_wdata;
		bh_rd_q <= bucket_mem[q_bucket];
	end

	always_ff @(posedge clk) begin
		if (nd_we)
			key_mem[nv_waddr[AW-1:0]] <= key_q;
		key_rd_q <= key_mem[nd_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (nv_we)
			val_mem[nv_waddr[AW-1:0]] <= val_q;
		val_rd_q <= val_mem[nd_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (nn_we)
			next_mem[nn_waddr[AW-1:0]] <= nn_wdata;
		nxt_rd_q <= next_mem[nd_raddr[AW-1:0]];
	end

	always_comb begin
		res_status = ST_OK;
		if (cmd_q == CMD_GET && !hit_q)
			res_status = ST_NOT_FOUND;
		else if (cmd_q == CMD_PUT && !hit_q && nofree_q)
			res_status = ST_POOL_FULL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			free_head_q  <= '0;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_GET;
			out_status_q <= ST_OK;
		end else begin
			// in S_REPLY a pop of the held item is followed by the new one below
			if (pop && out_valid_q && state_q != S_REPLY)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKET_COUNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q    <= cmd_e_t'(q_command);
						key_q    <= q_key[KW-1:0];
						val_q    <= q_value[VW-1:0];
						bkt_q    <= q_bucket;
						hit_q    <= 1'b0;
						nofree_q <= 1'b0;
						prev_q   <= NIL;
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: begin
					cur_q <= bh_rd_q;
					if (bh_rd_q == NIL)
						state_q <= S_EXEC;
					else
						state_q <= S_NODE;
				end
				S_NODE: begin
					if (key_rd_q == key_q) begin
						hit_q     <= 1'b1;
						hitval_q  <= val_rd_q;
						hitnext_q <= nxt_rd_q;
						state_q   <= S_EXEC;
					end else begin
						prev_q <= cur_q;
						cur_q  <= nxt_rd_q;
						if (nxt_rd_q == NIL)
							state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_REPLY;
					if (cmd_q == CMD_PUT && !hit_q) begin
						if (free_head_q == NIL) begin
							nofree_q <= 1'b1;
						end else begin
							fresh_q <= free_head_q;
							state_q <= S_LINK;
						end
					end else if (cmd_q == CMD_REMOVE && hit_q) begin
						free_head_q <= cur_q;
						state_q     <= S_LINK;
					end
				end
				S_LINK: begin
					if (cmd_q == CMD_PUT) begin
						// a node never handed out yet is the fill mark itself
						if (fresh_q == fill_q) begin
							free_head_q <= fresh_q + NW'(1);
							fill_q      <= fresh_q + NW'(1);
						end else begin
							free_head_q <= nxt_rd_q;
						end
					end
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (!out_valid_q || pop) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPLY && (!out_valid_q || pop)) begin
			out_found_q <= hit_q;
			out_val_q   <= (cmd_q == CMD_GET && hit_q) ? hitval_q : '0;
		end
	end

	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign clearing   = state_q == S_CLR;
	assign empty      = !out_valid_q;
	assign found      = out_found_q;
	assign read_value = FIELD_BITS'(out_val_q);
	assign status     = out_status_q;

endmodule

[rtl/core/chained_hash_map_engine.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key/value map in buckets of linked chains drawn from a fixed node pool.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          command, key, value
//  result    empty / pop          found, read_value, status
//
//  An item passes the chain walker states idle, head, node (once per chain node
//  visited), exec and reply, plus link for a put of a new key while a node is free
//  or a remove of a present key. The bucket is the masked key mod BUCKET_COUNT:
//  the low key bits when that is a power of two, else worked out in the front at
//  4 key bits per cycle, overlapped with the back. After reset the bucket table is swept with full high.
//  A two-entry queue and the result register let both sides stall apart.
module chained_hash_map_engine #(
	parameter int BUCKET_COUNT = chm_pkg::DEF_BUCKET_COUNT,
	parameter int NODE_COUNT   = chm_pkg::DEF_NODE_COUNT,
	parameter int KEY_BITS     = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS   = chm_pkg::DEF_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     command,
	input  logic [chm_pkg::FIELD_BITS-1:0] key,
	input  logic [chm_pkg::FIELD_BITS-1:0] value,
	output logic                           empty,
	input  logic                           pop,
	output logic                           found,
	output logic [chm_pkg::FIELD_BITS-1:0] read_value,
	output logic [1:0]                     status
);
	import chm_pkg::*;

	localparam int BW = BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1;

	logic                  clearing;
	logic                  q_empty;
	logic                  q_pop;
	logic [1:0]            q_command;
	logic [FIELD_BITS-1:0] q_key;
	logic [FIELD_BITS-1:0] q_value;
	logic [BW-1:0]         q_bucket;

	chm_front #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.KEY_BITS    (KEY_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.push     (push),
		.full     (full),
		.command  (command),
		.key      (key),
		.value    (value),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_command(q_command),
		.q_key    (q_key),
		.q_value  (q_value),
		.q_bucket (q_bucket)
	);

	chm_back #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.NODE_COUNT  (NODE_COUNT),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_command (q_command),
		.q_key     (q_key),
		.q_value   (q_value),
		.q_bucket  (q_bucket),
		.empty     (empty),
		.pop       (pop),
		.found     (found),
		.read_value(read_value),
		.status    (status)
	);

`ifndef NO_ASSERTIONS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("item accepted during table sweep");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && read_value != '0) |-> (found && status == ST_OK))
		else $error("value returned without a hit");

	a_full_means_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_POOL_FULL) |-> !found)
		else $error("pool full reported on a present key");

	a_no_pop_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("queue read during table sweep");
`endif

endmodule
